/* src/blake2s_256_hash_core_defines.svh */
// Assertion macros used by the compression engine of the hash core.
// Depends on nothing; expects clk and arst_n in the including scope.
`ifndef BLAKE2S_256_HASH_CORE_DEFINES_SVH
`define BLAKE2S_256_HASH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define B2S_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define B2S_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/b2s_pkg.sv */
// Shared types, constants and functions of the BLAKE2s-256 hash core.
// Depends on nothing.
package b2s_pkg;

	localparam logic [31:0] PARAM_WORD = 32'h01010020;

	localparam logic [7:0][31:0] IV = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	localparam int unsigned ROUNDS = 10;

	// One compression job handed from front to back.
	typedef struct packed {
		logic [15:0][31:0] blk;
		logic [63:0]       cnt;
		logic              fin;
	} job_t;

	function automatic logic [7:0][31:0] chain_init();
		logic [7:0][31:0] h;
		h = IV;
		h[0] = IV[0] ^ PARAM_WORD;
		return h;
	endfunction

	// Message schedule: word index for position k of round r.
	function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
		logic [63:0] row;
		case (r)
			4'd0: row = 64'hFEDCBA9876543210;
			4'd1: row = 64'h357B20C16DF984AE;
			4'd2: row = 64'h491763EADF250C8B;
			4'd3: row = 64'h8F04A562EBCD1397;
			4'd4: row = 64'hD386CB1EFA427509;
			4'd5: row = 64'h91EF57D438B0A6C2;
			4'd6: row = 64'hB8293670A4DEF15C;
			4'd7: row = 64'hA2684F05931CE7BD;
			4'd8: row = 64'h5A417D2C803B9EF6;
			4'd9: row = 64'h0DC3E9BF5167482A;
			default: row = 64'h0;
		endcase
		return row[{k, 2'b00} +: 4];
	endfunction

endpackage

/* src/blake2s_256_hash_core.sv */
// BLAKE2s-256 hash core: at most one message byte per item, eight digest words per message.
// Bytes are taken one per cycle while data_stall is low; a block compression runs ten
// rounds of four half-mix steps on four G lanes, then folds into the chain value.
// A closing item yields its digest words once its final block has been folded;
// a two-job queue keeps bytes flowing while a block compresses.
// Asynchronous active-low reset loads the initial chain value and empties the job queue.
module blake2s_256_hash_core
	import b2s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic push;
	logic pop;
	logic q_full;
	logic q_avail;
	job_t push_job;
	job_t pop_job;

	// Front: pack each byte into the block, queue a job when the block must go.
	b2s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.is_last    (is_last),
		.push       (push),
		.push_job   (push_job),
		.q_full     (q_full)
	);

	// Queue: decouple the packer from the compression engine.
	b2s_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.avail    (q_avail),
		.pop_job  (pop_job)
	);

	// Back: compress each job and drive out the digest after a final block.
	b2s_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_avail      (q_avail),
		.q_job        (pop_job),
		.pop          (pop),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

endmodule

/* src/b2s_queue.sv */
// Two-entry job queue between the byte packer and the compression engine.
// Depends on b2s_pkg.
module b2s_queue
	import b2s_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic avail,
	output job_t pop_job
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/b2s_front.sv */
// Byte packer: gathers bytes into a block and queues compression jobs.
// Depends on b2s_pkg.
module b2s_front
	import b2s_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       is_last,
	output logic       push,
	output job_t       push_job,
	input  logic       q_full
);

	logic [15:0][31:0] buf_q;
	logic [6:0]        cnt_q;
	logic [63:0]       total_q;

	logic              blk_full;
	logic              need_nf;
	logic              need;
	logic              push_nf;
	logic              accept;
	logic [15:0][31:0] base_buf;
	logic [6:0]        base_cnt;
	logic [15:0][31:0] merged;

	assign blk_full   = cnt_q[6];
	assign need_nf    = has_byte & blk_full;
	assign need       = need_nf | is_last;
	// A closing byte onto a full block needs two jobs: hold the item while the full block is queued.
	assign data_stall = (need & q_full) | (need_nf & is_last);
	assign accept     = data_valid & ~data_stall;
	assign push_nf    = data_valid & need_nf & ~q_full;
	assign push       = push_nf | (accept & is_last);

	assign base_buf = push_nf ? '0 : buf_q;
	assign base_cnt = push_nf ? 7'd0 : cnt_q;

	always_comb begin
		merged = base_buf;
		if (has_byte) begin
			merged[base_cnt[5:2]][{base_cnt[1:0], 3'b000} +: 8] = data_byte;
		end
	end

	always_comb begin
		if (push_nf) begin
			push_job.blk = buf_q;
			push_job.cnt = total_q;
			push_job.fin = 1'b0;
		end else begin
			push_job.blk = merged;
			push_job.cnt = total_q + {63'd0, has_byte};
			push_job.fin = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			cnt_q   <= 7'd0;
			total_q <= 64'd0;
		end else if (accept && is_last) begin
			buf_q   <= '0;
			cnt_q   <= 7'd0;
			total_q <= 64'd0;
		end else if (accept && has_byte) begin
			buf_q   <= merged;
			cnt_q   <= base_cnt + 7'd1;
			total_q <= total_q + 64'd1;
		end else if (push_nf) begin
			buf_q <= '0;
			cnt_q <= 7'd0;
		end
	end

endmodule

/* src/b2s_back.sv */
// Compression engine: four G lanes, one half-mix per cycle, digest output.
// Depends on b2s_pkg and the assertion macro header.
`include "blake2s_256_hash_core_defines.svh"
module b2s_back
	import b2s_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_avail,
	input  job_t        q_job,
	output logic        pop,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]        state_q;
	logic [3:0]        rnd_q;
	logic [1:0]        sub_q;
	logic [2:0]        idx_q;
	logic              fin_q;
	logic [7:0][31:0]  h_q;
	logic [15:0][31:0] v_q;
	logic [15:0][31:0] m_q;
	logic [15:0][31:0] v_init;
	logic [15:0][31:0] v_step;
	logic              half;
	logic              diag;
	logic              out_take;

	assign half         = sub_q[0];
	assign diag         = sub_q[1];
	assign pop          = (state_q == ST_IDLE) & q_avail;
	assign digest_valid = (state_q == ST_OUT);
	assign digest_word  = h_q[0];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == 3'd7);
	assign out_take     = digest_valid & ~digest_stall;

	always_comb begin
		v_init[7:0]  = h_q;
		v_init[15:8] = IV;
		v_init[12]   = IV[4] ^ q_job.cnt[31:0];
		v_init[13]   = IV[5] ^ q_job.cnt[63:32];
		v_init[14]   = q_job.fin ? ~IV[6] : IV[6];
	end

	// Half of a G mix on four columns or four diagonals at once.
	always_comb begin
		logic [31:0] a, b, c, d, x, an, dn, cn, bn, dx, bx;
		logic [3:0]  ia, ib, ic, id;
		v_step = v_q;
		for (int i = 0; i < 4; i++) begin
			ia = 4'(i);
			ib = diag ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
			ic = diag ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
			id = diag ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
			a = v_q[ia];
			b = v_q[ib];
			c = v_q[ic];
			d = v_q[id];
			x = m_q[sigma(rnd_q, {diag, 3'(2 * i) | {2'b00, half}})];
			an = a + b + x;
			dx = d ^ an;
			dn = half ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
			cn = c + dn;
			bx = b ^ cn;
			bn = half ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};
			v_step[ia] = an;
			v_step[ib] = bn;
			v_step[ic] = cn;
			v_step[id] = dn;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			v_q <= v_init;
			m_q <= q_job.blk;
		end else if (state_q == ST_RUN) begin
			v_q <= v_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= 4'd0;
			sub_q   <= 2'd0;
			idx_q   <= 3'd0;
			fin_q   <= 1'b0;
			h_q     <= chain_init();
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						fin_q   <= q_job.fin;
						rnd_q   <= 4'd0;
						sub_q   <= 2'd0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd3) begin
						rnd_q <= rnd_q + 4'd1;
						if (rnd_q == 4'(ROUNDS - 1)) state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++)
						h_q[3'(i)] <= h_q[3'(i)] ^ v_q[4'(i)] ^ v_q[4'(i + 8)];
					idx_q   <= 3'd0;
					state_q <= fin_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (out_take) begin
						idx_q <= idx_q + 3'd1;
						if (last_word) begin
							h_q     <= chain_init();
							state_q <= ST_IDLE;
						end else begin
							h_q <= {32'd0, h_q[7:1]};
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`B2S_ASSERT_NOW(a_pop_idle, pop, state_q == ST_IDLE, "job taken while busy")
	`B2S_ASSERT_NOW(a_rnd_range, state_q == ST_RUN, rnd_q < 4'(ROUNDS), "round out of range")
	`B2S_ASSERT_NEXT(a_last_done, out_take && last_word, state_q == ST_IDLE, "engine not idle")

endmodule
